>>> rtl/tkf_pkg.sv
// ----------------------------------------------------------------------------
// tkf_pkg
// Shared types, codes and helpers for the tilt Kalman fusion block.
// ----------------------------------------------------------------------------
package tkf_pkg;

  // register indexes on the configuration channel
  localparam logic [2:0] REG_ACCEL_OFFSET  = 3'd0;
  localparam logic [2:0] REG_GYRO_OFFSET   = 3'd1;
  localparam logic [2:0] REG_ACCEL_GAIN    = 3'd2;
  localparam logic [2:0] REG_GYRO_GAIN     = 3'd3;
  localparam logic [2:0] REG_ANGLE_NOISE   = 3'd4;
  localparam logic [2:0] REG_BIAS_NOISE    = 3'd5;
  localparam logic [2:0] REG_MEASURE_NOISE = 3'd6;
  localparam logic [2:0] REG_STEP_TIME     = 3'd7;

  // register reset values
  localparam logic signed [15:0] RST_ACCEL_OFFSET = 16'sd1100;
  localparam logic signed [15:0] RST_GYRO_OFFSET  = -16'sd30;
  localparam logic signed [31:0] RST_ACCEL_GAIN   = 32'sd82182;
  localparam logic signed [31:0] RST_GYRO_GAIN    = -32'sd1023000;
  localparam logic [30:0] RST_ANGLE_NOISE   = 31'd268435;
  localparam logic [30:0] RST_BIAS_NOISE    = 31'd805306;
  localparam logic [30:0] RST_MEASURE_NOISE = 31'd134217728;
  localparam logic [30:0] RST_STEP_TIME     = 31'd2684355;

  // 1.0 in Q4.28
  localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

  localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
  localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

  // filter step micro-operations, in execution order
  typedef enum logic [3:0] {
    OP_MEAS, OP_RATE, OP_ANG, OP_PAA, OP_PAB, OP_PBB, OP_DIV0, OP_DIV1,
    OP_CBA, OP_CAA, OP_CBB, OP_CAB, OP_EB, OP_EA
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_RND, S_WB, S_DSTART, S_DWAIT, S_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic mul_go;
    logic rnd_go;
    logic wb_go;
    logic div_start;
    logic out_load;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

  // saturate a wide signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7FFFFFFF;
    else if (v < SAT_LO) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/tilt_kalman_fusion_top.sv
// One item at a time: a new sample pair is taken only after the previous step has
// loaded its result. Each step runs 12 multiply ops (multiply, round, write-back)
// on one shared 34x32 multiplier, plus two bit-serial divisions that end early
// when the denominator is zero or the gain saturates. A finished result waits in
// the output register while the next item is processed, and a held result stalls that step.
// Reset (rst_ni low, async) restores register defaults and the filter state.
// ----------------------------------------------------------------------------
// tilt_kalman_fusion_top
// Accelerometer/gyro tilt fusion with a two-state Kalman filter.
// ----------------------------------------------------------------------------
module tilt_kalman_fusion_top
  import tkf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] accel_sample, [31:16] gyro_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] fused_angle, [63:32] corrected_rate
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  tkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tkf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> rtl/tkf_div.sv
// ----------------------------------------------------------------------------
// tkf_div
// Bit-serial signed divider: Q4.28 / Q4.28 -> Q8.24, truncated, saturated.
// ----------------------------------------------------------------------------
module tkf_div
  import tkf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [32:0] den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  logic [32:0] d_q;
  logic [32:0] r_q;
  logic [30:0] sh_q;
  logic [30:0] q_q;

  logic [31:0] n_mag;
  logic [32:0] d_mag;
  logic [33:0] trial;
  logic        fits;

  // operand magnitudes
  assign n_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign d_mag = den_i[32] ? 33'(-den_i) : 33'(den_i);

  // one restoring step
  assign trial = {r_q, sh_q[30]};
  assign fits  = trial >= {1'b0, d_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (d_mag == '0 || {8'd0, n_mag} >= {d_mag, 7'd0}) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[31] ^ den_i[32];
      d_q   <= d_mag;
      r_q   <= 33'(n_mag[31:7]);
      sh_q  <= {n_mag[6:0], 24'd0};
      if (d_mag == '0) q_q <= '0;
      else if ({8'd0, n_mag} >= {d_mag, 7'd0}) q_q <= '1;
      else q_q <= '0;
    end else if (busy_q) begin
      r_q  <= fits ? 33'(trial - {1'b0, d_q}) : trial[32:0];
      sh_q <= {sh_q[29:0], 1'b0};
      q_q  <= {q_q[29:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

>>> rtl/tkf_datapath.sv
// ----------------------------------------------------------------------------
// tkf_datapath
// Config registers, filter state, shared multiplier, divider, output register.
// ----------------------------------------------------------------------------
module tkf_datapath
  import tkf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [31:0] in_data_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_data_o
);

  logic signed [15:0] acc_off_q, gyr_off_q;
  logic signed [31:0] acc_gain_q, gyr_gain_q;
  logic [30:0] an_q, bn_q, mn_q, step_q;

  logic signed [15:0] accel_q, gyro_q;
  logic signed [31:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
  logic signed [31:0] meas_q, rate_q, k0_q, k1_q;

  logic signed [34:0] op_a, err, rmb;
  logic signed [31:0] op_b;
  logic        sub;
  logic [33:0] mag_a;
  logic [31:0] mag_b;
  logic [65:0] prod_q;
  logic        neg_q;
  logic [65:0] rnd;
  logic signed [47:0] rv_q;
  logic signed [31:0] base;
  logic signed [31:0] sum_sat, sum2_sat;

  logic        out_valid_q;
  logic [63:0] out_data_q;

  logic               div_busy, div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] div_num;
  logic signed [32:0] den;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_off_q  <= RST_ACCEL_OFFSET;
      gyr_off_q  <= RST_GYRO_OFFSET;
      acc_gain_q <= RST_ACCEL_GAIN;
      gyr_gain_q <= RST_GYRO_GAIN;
      an_q       <= RST_ANGLE_NOISE;
      bn_q       <= RST_BIAS_NOISE;
      mn_q       <= RST_MEASURE_NOISE;
      step_q     <= RST_STEP_TIME;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ACCEL_OFFSET:  acc_off_q  <= cfg_data_i[15:0];
        REG_GYRO_OFFSET:   gyr_off_q  <= cfg_data_i[15:0];
        REG_ACCEL_GAIN:    acc_gain_q <= cfg_data_i;
        REG_GYRO_GAIN:     gyr_gain_q <= cfg_data_i;
        REG_ANGLE_NOISE:   an_q       <= cfg_data_i[30:0];
        REG_BIAS_NOISE:    bn_q       <= cfg_data_i[30:0];
        REG_MEASURE_NOISE: mn_q       <= cfg_data_i[30:0];
        REG_STEP_TIME:     step_q     <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      accel_q <= in_data_i[15:0];
      gyro_q  <= in_data_i[31:16];
    end
  end

  assign err = 35'(meas_q) - 35'(ang_q);
  assign rmb = 35'(rate_q) - 35'(bias_q);

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b0;
    case (cmd_i.op)
      OP_MEAS: begin
        op_a = 35'(accel_q) - 35'(acc_off_q);
        op_b = acc_gain_q;
      end
      OP_RATE: begin
        op_a = 35'(gyro_q) - 35'(gyr_off_q);
        op_b = gyr_gain_q;
      end
      OP_ANG: begin
        op_a = rmb;
        op_b = $signed({1'b0, step_q});
      end
      OP_PAA: begin
        op_a = 35'($signed({1'b0, an_q})) - 35'(cab_q) - 35'(cba_q);
        op_b = $signed({1'b0, step_q});
      end
      OP_PAB: begin
        op_a = -35'(cbb_q);
        op_b = $signed({1'b0, step_q});
      end
      OP_PBB: begin
        op_a = 35'($signed({1'b0, bn_q}));
        op_b = $signed({1'b0, step_q});
      end
      OP_CBA: begin
        op_a = 35'(k1_q);
        op_b = caa_q;
        sub  = 1'b1;
      end
      OP_CAA: begin
        op_a = 35'(k0_q);
        op_b = caa_q;
        sub  = 1'b1;
      end
      OP_CBB: begin
        op_a = 35'(k1_q);
        op_b = cab_q;
        sub  = 1'b1;
      end
      OP_CAB: begin
        op_a = 35'(k0_q);
        op_b = cab_q;
        sub  = 1'b1;
      end
      OP_EB: begin
        op_a = err;
        op_b = k1_q;
      end
      OP_EA: begin
        op_a = err;
        op_b = k0_q;
      end
      default: ;
    endcase
  end

  assign mag_a = op_a[34] ? 34'(-op_a) : op_a[33:0];
  assign mag_b = op_b[31] ? 32'(-op_b) : 32'(op_b);

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      prod_q <= 66'(mag_a) * 66'(mag_b);
      neg_q  <= op_a[34] ^ op_b[31] ^ sub;
    end
  end

  // round half away from zero on the magnitude, then apply sign
  always_comb begin
    case (cmd_i.op)
      OP_MEAS, OP_RATE:                 rnd = (prod_q + 66'd128) >> 8;
      OP_ANG, OP_PAA, OP_PAB, OP_PBB:   rnd = (prod_q + 66'd134217728) >> 28;
      default:                          rnd = (prod_q + 66'd8388608) >> 24;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd_go) begin
      rv_q <= neg_q ? -$signed(rnd[47:0]) : $signed(rnd[47:0]);
    end
  end

  // accumulate base
  always_comb begin
    case (cmd_i.op)
      OP_ANG, OP_EA:  base = ang_q;
      OP_EB:          base = bias_q;
      OP_PAA, OP_CAA: base = caa_q;
      OP_PAB, OP_CAB: base = cab_q;
      OP_CBA:         base = cba_q;
      OP_PBB, OP_CBB: base = cbb_q;
      default:        base = '0;
    endcase
  end

  assign sum_sat  = sat32(49'(base) + 49'(rv_q));
  assign sum2_sat = sat32(49'(cba_q) + 49'(rv_q));

  // divider operands
  assign den     = 33'($signed({1'b0, mn_q})) + 33'(caa_q);
  assign div_num = (cmd_i.op == OP_DIV0) ? caa_q : cba_q;

  tkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // filter state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q  <= '0;
      bias_q <= '0;
      caa_q  <= ONE_Q28;
      cab_q  <= '0;
      cba_q  <= '0;
      cbb_q  <= ONE_Q28;
      meas_q <= '0;
      rate_q <= '0;
      k0_q   <= '0;
      k1_q   <= '0;
    end else begin
      if (cmd_i.wb_go) begin
        case (cmd_i.op)
          OP_MEAS:        meas_q <= sum_sat;
          OP_RATE:        rate_q <= sum_sat;
          OP_ANG, OP_EA:  ang_q  <= sum_sat;
          OP_EB:          bias_q <= sum_sat;
          OP_PAA, OP_CAA: caa_q  <= sum_sat;
          OP_PAB: begin
            cab_q <= sum_sat;
            cba_q <= sum2_sat;
          end
          OP_CAB:         cab_q  <= sum_sat;
          OP_CBA:         cba_q  <= sum_sat;
          OP_PBB, OP_CBB: cbb_q  <= sum_sat;
          default: ;
        endcase
      end
      if (div_done) begin
        if (cmd_i.op == OP_DIV0) k0_q <= div_q;
        else k1_q <= div_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {sat32(49'(rate_q) - 49'(bias_q)), ang_q};
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

endmodule

>>> rtl/tkf_ctrl.sv
// ----------------------------------------------------------------------------
// tkf_ctrl
// Sequencer for one filter step: multiply ops, two divisions, output load.
// ----------------------------------------------------------------------------
module tkf_ctrl
  import tkf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;
  op_e    op_q, op_d, op_nxt;

  assign op_nxt = op_e'(4'(op_q) + 4'd1);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_MEAS;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          op_d    = OP_MEAS;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_go = 1'b1;
        state_d = S_RND;
      end
      S_RND: begin
        cmd_o.rnd_go = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        cmd_o.wb_go = 1'b1;
        if (op_q == OP_EA) begin
          state_d = S_OUT;
        end else begin
          op_d    = op_nxt;
          state_d = (op_nxt == OP_DIV0) ? S_DSTART : S_MUL;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          op_d    = op_nxt;
          state_d = (op_nxt == OP_DIV1) ? S_DSTART : S_MUL;
        end
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  // no second item is taken while a step runs
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted during a filter step");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("output register overwritten");

  // divider is started only when idle and only for a gain op
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> (!sts_i.div_busy && (op_q == OP_DIV0 || op_q == OP_DIV1)))
    else $error("divider started while busy or for wrong op");
`endif

endmodule

>>> test/tilt_kalman_fusion_checker.sv
// ----------------------------------------------------------------------------
// tilt_kalman_fusion_checker
// Watches the sample, result and register-write channels of the tilt fusion
// block. It keeps its own copy of the filter state and registers, works out
// the fused angle and corrected rate for each accepted sample pair, and
// compares each result transfer against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tilt_kalman_fusion_checker
  import tkf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          err_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] rate;
    logic signed [31:0] angle;
  } fusion_res_t;

  localparam longint BIG = longint'(1) << 62;

  longint a_off, g_off, a_gain, g_gain, q_ang, q_bias, r_meas, dt;
  longint ang_est, bias_est, p_aa, p_ab, p_ba, p_bb;
  fusion_res_t fused_q[$];
  int errors;

  assign err_cnt_o = errors;
  assign pending_o = fused_q.size();

  function automatic longint clamp(longint v);
    return v > 64'sh7FFFFFFF ? 64'sh7FFFFFFF : (v < -64'sh80000000 ? -64'sh80000000 : v);
  endfunction

  // exact product, shifted with rounding half away from zero, capped at 2^62
  function automatic longint scale_mul(longint a, longint b, int sh);
    logic [127:0] p;
    logic [127:0] r;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    r = (p + (128'd1 << (sh - 1))) >> sh;
    if (r > 128'(BIG)) r = 128'(BIG);
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  // Q4.28 / Q4.28 -> Q8.24, truncated toward zero
  function automatic longint gain_quot(longint num, longint den);
    logic [127:0] n, d, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = 128'(num < 0 ? -num : num);
    d = 128'(den < 0 ? -den : den);
    if (d == 0) return 0;
    if (n / d >= 128) return neg ? -longint'(32'h7FFFFFFF) : longint'(32'h7FFFFFFF);
    q = (n << 24) / d;
    if (q > 128'h7FFFFFFF) q = 128'h7FFFFFFF;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic restore_defaults();
    a_off = 1100; g_off = -30; a_gain = 82182; g_gain = -1023000;
    q_ang = 268435; q_bias = 805306; r_meas = 134217728; dt = 2684355;
    ang_est = 0; bias_est = 0; p_aa = ONE_Q28; p_ab = 0; p_ba = 0; p_bb = ONE_Q28;
  endtask

  task automatic fuse_sample(logic signed [15:0] acc, logic signed [15:0] gyr);
    longint a, g, meas, rate, d_aa, err, den, k0, k1, t0, t1;
    fusion_res_t r;
    a = longint'(acc) - a_off;
    g = longint'(gyr) - g_off;
    meas = clamp(scale_mul(a, a_gain, 8));
    rate = clamp(scale_mul(g, g_gain, 8));
    // predict
    ang_est = clamp(ang_est + scale_mul(rate - bias_est, dt, 28));
    d_aa = q_ang - p_ab - p_ba;
    p_aa = clamp(p_aa + scale_mul(d_aa, dt, 28));
    p_ab = clamp(p_ab + scale_mul(-p_bb, dt, 28));
    p_ba = clamp(p_ba + scale_mul(-p_bb, dt, 28));
    p_bb = clamp(p_bb + scale_mul(q_bias, dt, 28));
    // gain
    err = meas - ang_est;
    den = r_meas + p_aa;
    k0 = gain_quot(p_aa, den);
    k1 = gain_quot(p_ba, den);
    // correct
    t0 = p_aa; t1 = p_ab;
    p_aa = clamp(p_aa - scale_mul(k0, t0, 24));
    p_ab = clamp(p_ab - scale_mul(k0, t1, 24));
    p_ba = clamp(p_ba - scale_mul(k1, t0, 24));
    p_bb = clamp(p_bb - scale_mul(k1, t1, 24));
    ang_est = clamp(ang_est + scale_mul(k0, err, 24));
    bias_est = clamp(bias_est + scale_mul(k1, err, 24));
    r.angle = ang_est[31:0];
    r.rate = clamp(rate - bias_est);
    fused_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fusion_res_t e, got;
    if (!rst_ni) begin
      restore_defaults();
      fused_q.delete();
      errors = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACCEL_OFFSET:  a_off = longint'($signed(cfg_data[15:0]));
          REG_GYRO_OFFSET:   g_off = longint'($signed(cfg_data[15:0]));
          REG_ACCEL_GAIN:    a_gain = longint'($signed(cfg_data));
          REG_GYRO_GAIN:     g_gain = longint'($signed(cfg_data));
          REG_ANGLE_NOISE:   q_ang = longint'(cfg_data[30:0]);
          REG_BIAS_NOISE:    q_bias = longint'(cfg_data[30:0]);
          REG_MEASURE_NOISE: r_meas = longint'(cfg_data[30:0]);
          REG_STEP_TIME:     dt = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      // result transfers against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (fused_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
        end else begin
          e = fused_q.pop_front();
          if (got.angle !== e.angle) begin
            errors++;
            $display("%0t: fused_angle exp %0d got %0d", $time, e.angle, got.angle);
          end
          if (got.rate !== e.rate) begin
            errors++;
            $display("%0t: corrected_rate exp %0d got %0d", $time, e.rate, got.rate);
          end
        end
      end
      // sample transfers
      if (s_axis_tvalid && s_axis_tready)
        fuse_sample(s_axis_tdata[15:0], s_axis_tdata[31:16]);
    end
  end

  // leftover expectations are reported by the top through pending_o
endmodule

>>> test/tilt_kalman_fusion_top_tb.sv
// ----------------------------------------------------------------------------
// tilt_kalman_fusion_top_tb
// Drives sample pairs and register writes into the tilt fusion block with
// bursty sending and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tilt_kalman_fusion_top_tb;
  import tkf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          err_cnt, pending, idle_cycles;
  bit          hold_rx = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tilt_kalman_fusion_top u_top (.*);

  tilt_kalman_fusion_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // receiver: own stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tilt_kalman_fusion_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // send one sample pair; optional random gap afterwards
  task automatic send_pair(logic [15:0] acc, logic [15:0] gyr, bit gap);
    s_axis_tdata <= {gyr, acc};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (gap) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 150)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic random_burst(int n);
    int left;
    bit gap;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) left = $urandom_range(1, 12);
      left--;
      gap = (left == 0);
      if ($urandom_range(0, 5) == 0)
        send_pair(16'($urandom), 16'($urandom), gap);
      else
        send_pair(16'($signed($urandom_range(0, 4000)) - 2000 + 1100),
                  16'($signed($urandom_range(0, 600)) - 300), gap);
    end
  endtask

  task automatic random_regs();
    write_reg(REG_ACCEL_OFFSET, $urandom);
    write_reg(REG_GYRO_OFFSET, $urandom);
    write_reg(REG_ACCEL_GAIN, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000));
    write_reg(REG_GYRO_GAIN, $urandom_range(0, 1) ? $urandom : -$urandom_range(0, 2000000));
    write_reg(REG_ANGLE_NOISE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000000));
    write_reg(REG_BIAS_NOISE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000000));
    write_reg(REG_MEASURE_NOISE, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 300000000));
    write_reg(REG_STEP_TIME, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 30000000));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes with reset registers
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'h7FFF, 16'h7FFF, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'hFFFF, 16'h0001, 1'b0);
    send_pair(16'h044C, 16'hFFE2, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    drain();

    // register extremes: gain overflow, zero / negative innovation variance
    write_reg(REG_ACCEL_OFFSET, 32'h0000_8000);
    write_reg(REG_GYRO_OFFSET, 32'h0000_7FFF);
    write_reg(REG_ACCEL_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_GYRO_GAIN, 32'h8000_0000);
    write_reg(REG_ANGLE_NOISE, 32'h7FFF_FFFF);
    write_reg(REG_BIAS_NOISE, 32'h7FFF_FFFF);
    write_reg(REG_MEASURE_NOISE, 32'h0000_0001);
    write_reg(REG_STEP_TIME, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_pair(16'($urandom), 16'($urandom), 1'b0);
    drain();
    write_reg(REG_ANGLE_NOISE, 32'h0000_0000);
    write_reg(REG_BIAS_NOISE, 32'h0000_0000);
    write_reg(REG_STEP_TIME, 32'h0000_0001);
    write_reg(REG_ACCEL_GAIN, 32'h8000_0000);
    write_reg(REG_GYRO_GAIN, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_pair(16'($urandom), 16'($urandom), 1'b0);
    drain();

    // back to typical settings, with a long receiver hold-off
    write_reg(REG_ACCEL_OFFSET, 32'd1100);
    write_reg(REG_GYRO_OFFSET, -32'sd30);
    write_reg(REG_ACCEL_GAIN, 32'd82182);
    write_reg(REG_GYRO_GAIN, -32'sd1023000);
    write_reg(REG_ANGLE_NOISE, 32'd268435);
    write_reg(REG_BIAS_NOISE, 32'd805306);
    write_reg(REG_MEASURE_NOISE, 32'd134217728);
    write_reg(REG_STEP_TIME, 32'd2684355);
    hold_rx = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      random_burst(12);
    join
    random_burst(120);
    drain();

    // several random register settings
    for (int p = 0; p < 3; p++) begin
      random_regs();
      random_burst(90);
      drain();
    end

    if (err_cnt == 0 && pending == 0) begin
      $display("tilt_kalman_fusion_top_tb: clean");
    end else begin
      $display("tilt_kalman_fusion_top_tb: errors");
    end
    $finish;
  end
endmodule

>>> tilt_kalman_fusion_top.f
rtl/tkf_pkg.sv
rtl/tkf_div.sv
rtl/tkf_datapath.sv
rtl/tkf_ctrl.sv
rtl/tilt_kalman_fusion_top.sv
test/tilt_kalman_fusion_checker.sv
test/tilt_kalman_fusion_top_tb.sv
